// ===== rtl/flv_tag_splitter_macros.svh =====
// ----------------------------------------------------------------------------
// flv_tag_splitter assertion macros
// shared concurrent assertion forms for the tag splitter rtl
// ----------------------------------------------------------------------------
`ifndef FLV_TAG_SPLITTER_MACROS_SVH
`define FLV_TAG_SPLITTER_MACROS_SVH

`ifndef ASSERT_OFF

// condition must never hold at a clock edge
`define FLV_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: never");

// antecedent implies consequent in the same cycle
`define FLV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define FLV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define FLV_ASSERT_NEVER(lbl, cond)
`define FLV_ASSERT_IMPL(lbl, ante, cons)
`define FLV_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/flv_pkg.sv =====
// ----------------------------------------------------------------------------
// flv_pkg
// constants, codes and result type shared by the tag splitter modules
// ----------------------------------------------------------------------------
package flv_pkg;

    localparam int DEFAULT_MAX_AV_TAGS = 2;

    localparam int FILE_HDR_LEN  = 13;
    localparam int TAG_HDR_LEN   = 11;
    localparam int TAG_TRL_LEN   = 4;
    localparam int TAG_FRAME_LEN = TAG_HDR_LEN + TAG_TRL_LEN;
    localparam int SIG_LEN       = 3;

    localparam int HDR_CNT_W  = 4;
    localparam int SIZE_W     = 24;
    localparam int TAG_CNT_W  = SIZE_W + 1;

    localparam logic [7:0] KIND_AUDIO = 8'h08;
    localparam logic [7:0] KIND_VIDEO = 8'h09;
    localparam logic [7:0] KIND_META  = 8'h12;

    typedef enum logic [2:0] {
        ROLE_FILE_HDR  = 3'd0,
        ROLE_AV_TAG    = 3'd1,
        ROLE_META_BODY = 3'd2,
        ROLE_META_FRM  = 3'd3,
        ROLE_SKIPPED   = 3'd4,
        ROLE_IGNORED   = 3'd5
    } role_t;

    typedef enum logic [1:0] {
        STAT_BUSY    = 2'd0,
        STAT_ACCEPT  = 2'd1,
        STAT_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        role_t      role;
        logic       slot;
        logic       start;
        status_t    status;
    } result_t;

    // file signature "FLV"
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0:    val = 8'h46;
            2'd1:    val = 8'h4C;
            2'd2:    val = 8'h56;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic logic kind_is_av(input logic [7:0] kind);
        return (kind == KIND_AUDIO) || (kind == KIND_VIDEO);
    endfunction

endpackage

// ===== rtl/flv_tag_parse.sv =====
// ----------------------------------------------------------------------------
// flv_tag_parse
// parse state registers and the per-word classification and status logic
// ----------------------------------------------------------------------------
`include "flv_tag_splitter_macros.svh"

module flv_tag_parse
    import flv_pkg::*;
#(
    parameter int MAX_AV_TAGS = DEFAULT_MAX_AV_TAGS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    res
);

    localparam int AV_CNT_W = (MAX_AV_TAGS < 1) ? 1 : $clog2(MAX_AV_TAGS + 1);
    localparam logic [AV_CNT_W-1:0]  AV_MAX    = AV_CNT_W'(MAX_AV_TAGS);
    localparam logic [HDR_CNT_W-1:0] HDR_END   = HDR_CNT_W'(FILE_HDR_LEN);
    localparam logic [HDR_CNT_W-1:0] SIG_END   = HDR_CNT_W'(SIG_LEN);
    localparam logic [TAG_CNT_W-1:0] FRAME_LEN = TAG_CNT_W'(TAG_FRAME_LEN);
    localparam logic [TAG_CNT_W-1:0] HDR_LEN   = TAG_CNT_W'(TAG_HDR_LEN);
    localparam logic [TAG_CNT_W-1:0] SIZE_POS  = TAG_CNT_W'(3);

    logic [HDR_CNT_W-1:0] hdr_cnt_reg,  hdr_cnt_next;
    logic [TAG_CNT_W-1:0] tag_cnt_reg,  tag_cnt_next;
    logic [TAG_CNT_W-1:0] tag_size_reg, tag_size_next;
    logic [7:0]           tag_kind_reg, tag_kind_next;
    logic [AV_CNT_W-1:0]  av_cnt_reg,   av_cnt_next;
    logic                 meta_seen_reg, meta_seen_next;
    logic                 pend_reg,     pend_next;
    logic                 failed_reg,   failed_next;

    logic [TAG_CNT_W-1:0] pos_inc;
    logic [TAG_CNT_W:0]   pos_trl;
    logic [SIZE_W-1:0]    size_shift;

    always_comb
    begin
        hdr_cnt_next   = hdr_cnt_reg;
        tag_cnt_next   = tag_cnt_reg;
        tag_size_next  = tag_size_reg;
        tag_kind_next  = tag_kind_reg;
        av_cnt_next    = av_cnt_reg;
        meta_seen_next = meta_seen_reg;
        pend_next      = pend_reg;
        failed_next    = failed_reg;

        res.data   = data_byte;
        res.role   = ROLE_IGNORED;
        res.slot   = 1'b0;
        res.start  = 1'b0;
        res.status = STAT_BUSY;

        pos_inc    = tag_cnt_reg + TAG_CNT_W'(1);
        pos_trl    = {1'b0, tag_cnt_reg} + (TAG_CNT_W + 1)'(TAG_TRL_LEN);
        size_shift = {tag_size_reg[SIZE_W-9:0], data_byte};

        if (!failed_reg)
        begin
            if (hdr_cnt_reg < HDR_END)
            begin
                res.role = ROLE_FILE_HDR;
                if (hdr_cnt_reg < SIG_END && data_byte != sig_byte(hdr_cnt_reg[1:0]))
                    failed_next = 1'b1;
                hdr_cnt_next = hdr_cnt_reg + HDR_CNT_W'(1);
            end
            else
            begin
                if (tag_cnt_reg == '0)
                begin
                    // type byte opens a new tag
                    tag_kind_next = data_byte;
                    res.start     = 1'b1;
                    tag_size_next = '0;
                    pend_next     = (kind_is_av(data_byte) && av_cnt_reg >= AV_MAX)
                                 || (data_byte == KIND_META && meta_seen_reg);
                end
                else if (tag_cnt_reg < SIZE_POS)
                begin
                    tag_size_next = {1'b0, size_shift};
                end
                else if (tag_cnt_reg == SIZE_POS)
                begin
                    // total length including header and trailer
                    tag_size_next = {1'b0, size_shift} + FRAME_LEN;
                end

                if (pend_next)
                    res.role = ROLE_SKIPPED;
                else if (kind_is_av(tag_kind_next))
                begin
                    res.role = ROLE_AV_TAG;
                    res.slot = av_cnt_reg[0];
                end
                else if (tag_kind_next == KIND_META)
                begin
                    if (tag_cnt_reg >= HDR_LEN && pos_trl < {1'b0, tag_size_next})
                        res.role = ROLE_META_BODY;
                    else
                        res.role = ROLE_META_FRM;
                end
                else
                    res.role = ROLE_SKIPPED;

                tag_cnt_next = pos_inc;
                if (pos_inc == FRAME_LEN && pend_next)
                    failed_next = 1'b1;
                else if (pos_inc >= FRAME_LEN && pos_inc == tag_size_next)
                begin
                    if (kind_is_av(tag_kind_next))
                        av_cnt_next = av_cnt_reg + AV_CNT_W'(1);
                    else if (tag_kind_next == KIND_META)
                        meta_seen_next = 1'b1;
                    tag_cnt_next = '0;
                    pend_next    = 1'b0;
                end
            end
        end

        if (last_byte)
        begin
            if (failed_next || hdr_cnt_next < HDR_END || tag_cnt_next >= FRAME_LEN
                || !meta_seen_next)
                res.status = STAT_INVALID;
            else
                res.status = STAT_ACCEPT;
            // buffer done, start over
            hdr_cnt_next   = '0;
            tag_cnt_next   = '0;
            tag_size_next  = '0;
            tag_kind_next  = '0;
            av_cnt_next    = '0;
            meta_seen_next = 1'b0;
            pend_next      = 1'b0;
            failed_next    = 1'b0;
        end
        else
            res.status = failed_next ? STAT_INVALID : STAT_BUSY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg   <= '0;
            tag_cnt_reg   <= '0;
            tag_size_reg  <= '0;
            tag_kind_reg  <= '0;
            av_cnt_reg    <= '0;
            meta_seen_reg <= 1'b0;
            pend_reg      <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (step)
        begin
            hdr_cnt_reg   <= hdr_cnt_next;
            tag_cnt_reg   <= tag_cnt_next;
            tag_size_reg  <= tag_size_next;
            tag_kind_reg  <= tag_kind_next;
            av_cnt_reg    <= av_cnt_next;
            meta_seen_reg <= meta_seen_next;
            pend_reg      <= pend_next;
            failed_reg    <= failed_next;
        end
    end

    `FLV_ASSERT_NEVER(a_av_cnt_max, av_cnt_reg > AV_MAX)
    `FLV_ASSERT_NEVER(a_hdr_cnt_max, hdr_cnt_reg > HDR_END)
    `FLV_ASSERT_NEXT(a_last_clears, step && last_byte, hdr_cnt_reg == '0 && !failed_reg && tag_cnt_reg == '0)
    `FLV_ASSERT_IMPL(a_tag_after_hdr, tag_cnt_reg != '0, hdr_cnt_reg == HDR_END)

endmodule

// ===== rtl/flv_tag_splitter.sv =====
// ----------------------------------------------------------------------------
// flv_tag_splitter
// byte-serial role tagging and validation of an flv header buffer
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the output is not stalled and returns each
// byte with its role, slot, tag start flag and buffer status. Throughput is
// one word per clock when the output does not stall. A word accepted into
// the input register is parsed out of it, and its result is loaded into the
// result register and held there until taken. The parse state is updated as
// each word moves between the two registers. A stalled output holds one
// result while one more input word waits in the input register. All parse
// state clears after a last byte.
`include "flv_tag_splitter_macros.svh"

module flv_tag_splitter
    import flv_pkg::*;
#(
    parameter int MAX_AV_TAGS = DEFAULT_MAX_AV_TAGS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_out,
    output logic [2:0] role,
    output logic       av_slot,
    output logic       tag_start,
    output logic [1:0] status
);

    logic       in_vld_reg,  in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_vld_reg, out_vld_next;
    result_t    out_res_reg;
    result_t    res;
    logic       out_load;
    logic       step;
    logic       in_take;

    assign out_load = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && out_load;
    assign in_stall = in_vld_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_vld_next = 1'b1;
        else if (step)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
        out_vld_next = out_load ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (step)
            out_res_reg <= res;
    end

    flv_tag_parse #(
        .MAX_AV_TAGS (MAX_AV_TAGS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    assign out_valid = out_vld_reg;
    assign byte_out  = out_res_reg.data;
    assign role      = out_res_reg.role;
    assign av_slot   = out_res_reg.slot;
    assign tag_start = out_res_reg.start;
    assign status    = out_res_reg.status;

    `FLV_ASSERT_IMPL(a_stall_full, in_stall, in_vld_reg && out_vld_reg)
    `FLV_ASSERT_NEXT(a_step_fills_out, step, out_vld_reg)

endmodule
